[src/fup_pkg.sv]
package fup_pkg;

  // Phases of the front end's string parser
  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_SLASH    = 3'd1,
    PH_HOST     = 3'd2,
    PH_HOSTPASS = 3'd3,
    PH_PATH     = 3'd4,
    PH_ECHO     = 3'd5,
    PH_DISCARD  = 3'd6
  } phase_t;

  localparam int PREFIX_LEN = 6;
  localparam int HOST_MAX   = 9;
  localparam int CMD_MAX    = 12;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // "file:/" and "localhost"
  localparam logic [7:0] URL_HEAD [PREFIX_LEN] = '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h3A, 8'h2F};
  localparam logic [7:0] LOCAL_NAME [HOST_MAX] =
    '{8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h68, 8'h6F, 8'h73, 8'h74};

  typedef logic [CMD_MAX-1:0][7:0] cmd_bytes_t;

  // One queued command: up to CMD_MAX result words for one input word
  typedef struct packed {
    cmd_bytes_t  bytes;
    logic [3:0]  count;
    logic        bare;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_cut(input logic [7:0] c);
    return (c == CH_QUES) || (c == CH_HASH);
  endfunction

  // A host is shown unless empty or exactly "localhost"
  function automatic logic host_shown(input logic [3:0] len, input logic local_host);
    return (len != 4'd0) && !((len == 4'(HOST_MAX)) && local_host);
  endfunction

endpackage

[src/fup_front.sv]
module fup_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          push,
  output fup_pkg::cmd_t cmd
);
  import fup_pkg::*;

  phase_t      phase_r, phase_nxt;
  phase_t      phase_step;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  store_r [HOST_MAX];
  logic [7:0]  store_nxt [HOST_MAX];
  logic [3:0]  hlen_r, hlen_nxt;
  logic        hlocal_r, hlocal_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [7:0]  digit_r, digit_nxt;

  logic        take;
  logic [2:0]  pidx;
  logic        head_match;
  cmd_bytes_t  b;
  logic [3:0]  n;

  assign take       = in_valid && !q_full;
  assign pidx       = (pcnt_r >= 3'(PREFIX_LEN)) ? 3'd0 : pcnt_r;
  assign head_match = to_lower(in_byte) == URL_HEAD[pidx];

  // Next phase; phase_step is the phase before the end of string resets it
  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      PH_PREFIX: begin
        if (!head_match) begin
          phase_step = PH_ECHO;
        end else if (pidx == 3'(PREFIX_LEN - 1)) begin
          phase_step = PH_SLASH;
        end
      end
      PH_SLASH: begin
        if (in_byte == CH_SLASH) begin
          phase_step = PH_HOST;
        end else if (is_cut(in_byte)) begin
          phase_step = PH_DISCARD;
        end else begin
          phase_step = PH_PATH;
        end
      end
      PH_HOST: begin
        if (in_byte == CH_SLASH) begin
          phase_step = PH_PATH;
        end else if (is_cut(in_byte)) begin
          phase_step = PH_DISCARD;
        end else if (hlen_r >= 4'(HOST_MAX)) begin
          phase_step = PH_HOSTPASS;
        end
      end
      PH_HOSTPASS: begin
        if (in_byte == CH_SLASH) begin
          phase_step = PH_PATH;
        end else if (is_cut(in_byte)) begin
          phase_step = PH_DISCARD;
        end
      end
      PH_PATH: begin
        if (is_cut(in_byte)) begin
          phase_step = PH_DISCARD;
        end
      end
      default: begin
        phase_step = phase_r;
      end
    endcase
    phase_nxt = in_last ? PH_PREFIX : phase_step;
  end

  // Build the command and update the parser's data state
  always_comb begin
    logic path_en;
    logic do_tail;
    logic new_local;
    b          = '0;
    n          = 4'd0;
    path_en    = 1'b0;
    do_tail    = 1'b0;
    new_local  = 1'b0;
    pcnt_nxt   = pcnt_r;
    store_nxt  = store_r;
    hlen_nxt   = hlen_r;
    hlocal_nxt = hlocal_r;
    pend_nxt   = pend_r;
    digit_nxt  = digit_r;

    case (phase_r)
      PH_PREFIX: begin
        store_nxt[4'(pidx)] = in_byte;
        for (int i = 0; i < PREFIX_LEN; i++) begin
          b[i] = store_r[i];
        end
        b[4'(pidx)] = in_byte;
        if (head_match) begin
          if (pidx == 3'(PREFIX_LEN - 1)) begin
            pcnt_nxt = 3'd0;
            if (in_last) begin
              b[0] = CH_SLASH;
              n    = 4'd1;
            end
          end else begin
            pcnt_nxt = pidx + 3'd1;
            if (in_last) begin
              n = 4'(pidx) + 4'd1;
            end
          end
        end else begin
          n        = 4'(pidx) + 4'd1;
          pcnt_nxt = 3'd0;
        end
      end
      PH_SLASH: begin
        if (in_byte == CH_SLASH) begin
          hlen_nxt   = 4'd0;
          hlocal_nxt = 1'b1;
        end else begin
          b[0] = CH_SLASH;
          n    = 4'd1;
          path_en = !is_cut(in_byte);
        end
      end
      PH_HOST: begin
        b[0] = CH_SLASH;
        b[1] = CH_SLASH;
        for (int i = 0; i < HOST_MAX; i++) begin
          b[i + 2] = store_r[i];
        end
        if (in_byte == CH_SLASH) begin
          if (host_shown(hlen_r, hlocal_r)) begin
            b[4'(hlen_r + 4'd2)] = CH_SLASH;
            n = hlen_r + 4'd3;
          end else begin
            b[0] = CH_SLASH;
            n    = 4'd1;
          end
        end else if (is_cut(in_byte)) begin
          if (host_shown(hlen_r, hlocal_r)) begin
            n = hlen_r + 4'd2;
          end
        end else if (hlen_r < 4'(HOST_MAX)) begin
          new_local            = hlocal_r && (to_lower(in_byte) == LOCAL_NAME[hlen_r]);
          store_nxt[hlen_r]    = in_byte;
          hlen_nxt             = hlen_r + 4'd1;
          hlocal_nxt           = new_local;
          b[4'(hlen_r + 4'd2)] = in_byte;
          if (in_last && host_shown(hlen_r + 4'd1, new_local)) begin
            n = hlen_r + 4'd3;
          end
        end else begin
          // tenth host word: spill the whole stored host at once
          b[CMD_MAX-1] = in_byte;
          n = 4'(CMD_MAX);
        end
      end
      PH_HOSTPASS: begin
        if (in_byte == CH_SLASH) begin
          b[0] = CH_SLASH;
          n    = 4'd1;
        end else if (!is_cut(in_byte)) begin
          b[0] = in_byte;
          n    = 4'd1;
        end
      end
      PH_PATH: begin
        if (is_cut(in_byte)) begin
          if (pend_r == 2'd1 || pend_r == 2'd2) begin
            b[n] = CH_PCT;
            n    = n + 4'd1;
          end
          if (pend_r == 2'd2) begin
            b[n] = digit_r;
            n    = n + 4'd1;
          end
          pend_nxt = 2'd0;
        end else begin
          path_en = 1'b1;
        end
      end
      PH_DISCARD: begin
        n = 4'd0;
      end
      default: begin
        b[0] = in_byte;
        n    = 4'd1;
      end
    endcase

    // Percent decoding
    if (path_en) begin
      case (pend_r)
        2'd1: begin
          if (is_hex(in_byte)) begin
            digit_nxt = in_byte;
            pend_nxt  = 2'd2;
          end else begin
            b[n]    = CH_PCT;
            n       = n + 4'd1;
            do_tail = 1'b1;
          end
        end
        2'd2: begin
          if (is_hex(in_byte)) begin
            b[n]     = {hex_val(digit_r), hex_val(in_byte)};
            n        = n + 4'd1;
            pend_nxt = 2'd0;
          end else begin
            b[n]    = CH_PCT;
            b[n + 4'd1] = digit_r;
            n       = n + 4'd2;
            do_tail = 1'b1;
          end
        end
        default: begin
          do_tail = 1'b1;
        end
      endcase
      if (do_tail) begin
        if (in_byte == CH_PCT) begin
          pend_nxt = 2'd1;
        end else begin
          pend_nxt = 2'd0;
          b[n]     = in_byte;
          n        = n + 4'd1;
        end
      end
    end

    // End of string: flush a dangling escape, then return to reset values
    if (in_last) begin
      if (phase_step == PH_PATH) begin
        if (pend_nxt == 2'd1 || pend_nxt == 2'd2) begin
          b[n] = CH_PCT;
          n    = n + 4'd1;
        end
        if (pend_nxt == 2'd2) begin
          b[n] = digit_nxt;
          n    = n + 4'd1;
        end
      end
      pcnt_nxt   = 3'd0;
      hlen_nxt   = 4'd0;
      hlocal_nxt = 1'b1;
      pend_nxt   = 2'd0;
      digit_nxt  = 8'd0;
    end
  end

  assign cmd.bytes = b;
  assign cmd.bare  = (n == 4'd0);
  assign cmd.count = (n == 4'd0) ? 4'd1 : n;
  assign cmd.last  = in_last;
  assign push      = take && ((n != 4'd0) || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      pcnt_r   <= 3'd0;
      hlen_r   <= 4'd0;
      hlocal_r <= 1'b1;
      pend_r   <= 2'd0;
      digit_r  <= 8'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      pcnt_r   <= pcnt_nxt;
      hlen_r   <= hlen_nxt;
      hlocal_r <= hlocal_nxt;
      pend_r   <= pend_nxt;
      digit_r  <= digit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store_r <= store_nxt;
    end
  end

endmodule

[src/fup_queue.sv]
module fup_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fup_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fup_pkg::cmd_t head_cmd
);
  import fup_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);

  cmd_t            ent_r [QDEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (PW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

endmodule

[src/fup_back.sv]
module fup_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  fup_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_has_byte,
  output logic          out_last
);
  import fup_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       has_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  // Load the output register whenever it is empty or being taken
  assign load   = head_valid && (!vld_r || !out_stall);
  assign at_end = (idx_r == head_cmd.count - 4'd1);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? 4'd0 : idx_r + 4'd1;
    end
    vld_nxt = load || (vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_cmd.bare ? 8'd0 : head_cmd.bytes[idx_r];
      has_r  <= !head_cmd.bare;
      last_r <= head_cmd.last && at_end;
    end
  end

  assign out_valid    = vld_r;
  assign out_byte     = byte_r;
  assign out_has_byte = has_r;
  assign out_last     = last_r;

endmodule

[src/file_url_to_path_stream.sv]
// Streaming converter from a file URL to a path. One word of the argument
// string is taken per cycle on the in_ channel (in_last on its final word)
// and the converted path leaves one word per cycle on the out_ channel, with
// out_last on the final word of each string and a bare end marker
// (out_has_byte low, out_byte zero) when the string's tail yields nothing.
// Strings that do not open with "file:/" in any letter case pass through
// unchanged; otherwise the query or fragment is dropped, an empty or
// localhost host is removed, any other host is kept as "//host", and %XX
// escapes in the path are decoded. Rate: one input word per cycle while each
// word yields at most one result and out_stall is low. A word that yields k
// results (at most 12, for a host of nine words or more) leaves as k output
// words. A two-entry command queue sits between the parser and the
// serialiser, so once it fills in_stall rises until the burst drains. A result
// word reaches the output through the command queue and then the output
// register.
module file_url_to_path_stream (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last
);
  import fup_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  // Hold the input while the command queue is full
  assign in_stall = q_full;

  // Front: parse each word and queue one command of its result words when it yields any or ends the string
  fup_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue: decouple parsing from the serialiser so each side stalls alone
  fup_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: emit the command's words one per cycle while out_stall is low, through the output register
  fup_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

[src/fup_checker.sv]
module fup_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_last
);

  // Drop any output word after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_has_byte) && $stable(out_last))
    else $error("stalled output word changed");

  // A bare end marker carries a zero word
  a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_byte == 8'd0)
    else $error("bare marker with non-zero word");

  // A bare marker only ever closes a string
  a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last)
    else $error("bare marker without out_last");

endmodule

bind file_url_to_path_stream fup_checker u_fup_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_has_byte (out_has_byte),
  .out_last     (out_last)
);

[verif/file_url_to_path_checker.sv]
`timescale 1ns / 1ps

module file_url_to_path_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_has_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         words_owed
);
  import fup_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       fin;
  } path_word_t;

  localparam logic [8*PREFIX_LEN-1:0] HEAD_TEXT  = "file:/";
  localparam logic [8*HOST_MAX-1:0]   LOCAL_TEXT = "localhost";

  path_word_t path_q[$];
  int         step_words;

  // Parser state mirrored at the block's widths
  phase_t     ph;
  logic [2:0] head_idx;
  logic [7:0] held [HOST_MAX];
  logic [3:0] host_len;
  logic       host_local;
  logic [1:0] esc_cnt;
  logic [7:0] esc_digit;

  function automatic logic [7:0] head_ch(input int k);
    return HEAD_TEXT[8*(PREFIX_LEN-1-k) +: 8];
  endfunction

  function automatic logic [7:0] local_ch(input int k);
    return LOCAL_TEXT[8*(HOST_MAX-1-k) +: 8];
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c | 8'h20;
    return c;
  endfunction

  // Nibble value of a hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    logic [7:0] f;
    f = fold_case(c);
    if (f >= "0" && f <= "9") return f - "0";
    if (f >= "a" && f <= "f") return f - "a" + 10;
    return -1;
  endfunction

  function automatic logic ends_path(input logic [7:0] c);
    return c == CH_QUES || c == CH_HASH;
  endfunction

  task automatic put_word(input logic [7:0] b);
    path_word_t w;
    w.b   = b;
    w.has = 1'b1;
    w.fin = 1'b0;
    path_q.insert(path_q.size(), w);
    step_words++;
  endtask

  task automatic reset_parser();
    ph = PH_PREFIX;
    head_idx = '0;
    host_len = '0;
    host_local = 1'b1;
    esc_cnt = '0;
    esc_digit = '0;
  endtask

  // Emit a half-read escape literally
  task automatic flush_escape();
    if (esc_cnt != 0) put_word(CH_PCT);
    if (esc_cnt == 2) put_word(esc_digit);
    esc_cnt = '0;
  endtask

  task automatic decode_path(input logic [7:0] c);
    if (esc_cnt == 1) begin
      if (hex_nibble(c) >= 0) begin
        esc_digit = c;
        esc_cnt = 2'd2;
        return;
      end
      put_word(CH_PCT);
    end else if (esc_cnt == 2) begin
      if (hex_nibble(c) >= 0) begin
        put_word(8'(hex_nibble(esc_digit) * 16 + hex_nibble(c)));
        esc_cnt = '0;
        return;
      end
      put_word(CH_PCT);
      put_word(esc_digit);
    end
    esc_cnt = '0;
    if (c == CH_PCT) esc_cnt = 2'd1;
    else put_word(c);
  endtask

  task automatic show_host();
    int i;
    if (host_len == 0 || (host_len == HOST_MAX && host_local)) return;
    put_word(CH_SLASH);
    put_word(CH_SLASH);
    for (i = 0; i < host_len; i++) put_word(held[i]);
  endtask

  // Expected path words caused by one accepted input word
  task automatic convert_word(input logic [7:0] c, input logic fin);
    int i;
    path_word_t w;
    step_words = 0;
    case (ph)
      PH_PREFIX: begin
        if (head_idx >= PREFIX_LEN) head_idx = '0;
        held[head_idx] = c;
        if (fold_case(c) == head_ch(head_idx)) begin
          head_idx++;
          if (head_idx == PREFIX_LEN) begin
            head_idx = '0;
            ph = PH_SLASH;
            if (fin) put_word(CH_SLASH);
          end else if (fin) begin
            for (i = 0; i < head_idx; i++) put_word(held[i]);
          end
        end else begin
          for (i = 0; i < head_idx; i++) put_word(held[i]);
          put_word(c);
          head_idx = '0;
          ph = PH_ECHO;
        end
      end
      PH_SLASH: begin
        if (c == CH_SLASH) begin
          ph = PH_HOST;
          host_len = '0;
          host_local = 1'b1;
        end else if (ends_path(c)) begin
          put_word(CH_SLASH);
          ph = PH_DISCARD;
        end else begin
          put_word(CH_SLASH);
          ph = PH_PATH;
          decode_path(c);
        end
      end
      PH_HOST: begin
        if (c == CH_SLASH) begin
          show_host();
          put_word(CH_SLASH);
          ph = PH_PATH;
        end else if (ends_path(c)) begin
          show_host();
          ph = PH_DISCARD;
        end else if (host_len < HOST_MAX) begin
          held[host_len] = c;
          if (fold_case(c) != local_ch(host_len)) host_local = 1'b0;
          host_len++;
          if (fin) show_host();
        end else begin
          put_word(CH_SLASH);
          put_word(CH_SLASH);
          for (i = 0; i < HOST_MAX; i++) put_word(held[i]);
          put_word(c);
          ph = PH_HOSTPASS;
        end
      end
      PH_HOSTPASS: begin
        if (c == CH_SLASH) begin
          put_word(CH_SLASH);
          ph = PH_PATH;
        end else if (ends_path(c)) begin
          ph = PH_DISCARD;
        end else begin
          put_word(c);
        end
      end
      PH_PATH: begin
        if (ends_path(c)) begin
          flush_escape();
          ph = PH_DISCARD;
        end else begin
          decode_path(c);
        end
      end
      PH_DISCARD: ;
      default: put_word(c);
    endcase
    if (fin) begin
      if (ph == PH_PATH) flush_escape();
      if (step_words == 0) begin
        w.b   = 8'h00;
        w.has = 1'b0;
        w.fin = 1'b1;
        path_q.insert(path_q.size(), w);
      end else begin
        w = path_q.pop_back();
        w.fin = 1'b1;
        path_q.insert(path_q.size(), w);
      end
      reset_parser();
    end
  endtask

  always @(posedge clk) begin : watch
    path_word_t want;
    if (!rst_n) begin
      reset_parser();
      path_q.delete();
      fail_count = 0;
    end else begin
      // Retire the output word before predicting, so a word can never match
      // an expectation raised at the same edge.
      if (out_valid && !out_stall) begin
        if (path_q.size() == 0) begin
          $error("out_byte: expected nothing, got %0h (has %0b last %0b)",
                 out_byte, out_has_byte, out_last);
          fail_count++;
        end else begin
          want = path_q.pop_front();
          if (out_byte !== want.b) begin
            $error("out_byte: expected %0h, got %0h", want.b, out_byte);
            fail_count++;
          end
          if (out_has_byte !== want.has) begin
            $error("out_has_byte: expected %0b, got %0b", want.has, out_has_byte);
            fail_count++;
          end
          if (out_last !== want.fin) begin
            $error("out_last: expected %0b, got %0b", want.fin, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) convert_word(in_byte, in_last);
    end
    words_owed = path_q.size();
  end

endmodule

[verif/file_url_to_path_stream_tb.sv]
`timescale 1ns / 1ps

module file_url_to_path_stream_tb;
  import fup_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;

  int fail_count;
  int words_owed;

  // Chance, in percent, that the sender idles or the receiver stalls a cycle
  int idle_pct  = 0;
  int stall_pct = 0;
  int words_sent = 0;

  logic [7:0] url_q[$];
  string      hex_set = "0123456789abcdefABCDEF";

  file_url_to_path_stream dut (.*);

  file_url_to_path_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: decide the stall afresh at every falling edge
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Flip the case of a letter at random; the prefix and localhost compare
  // without regard to case, so both spellings must behave alike.
  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1) == 1) return c - 8'h20;
    return c;
  endfunction

  // Path content leans on escapes and hex digits, with rare cut characters
  // so that most strings get deep into the decoder.
  function automatic logic [7:0] path_char();
    case ($urandom_range(19))
      0, 1, 2:    return CH_PCT;
      3, 4, 5, 6: return hex_set[$urandom_range(21)];
      7:          return ($urandom_range(1) == 1) ? CH_QUES : CH_HASH;
      8, 9:       return CH_SLASH;
      10, 11:     return 8'($urandom_range(255));
      default:    return mixed_case(8'("a" + $urandom_range(25)));
    endcase
  endfunction

  function automatic logic [7:0] host_char();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(255));
      1:       return ".";
      2:       return 8'("0" + $urandom_range(9));
      default: return mixed_case(8'("a" + $urandom_range(25)));
    endcase
  endfunction

  // Append one byte to the string being built
  task automatic add_byte(input logic [7:0] c);
    url_q.insert(url_q.size(), c);
  endtask

  // Append the first n characters of s, letters in random case
  task automatic add_mixed(input string s, input int n);
    for (int i = 0; i < n; i++) add_byte(mixed_case(s[i]));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_path(input int n);
    repeat (n) add_byte(path_char());
  endtask

  task automatic add_host();
    int n;
    case ($urandom_range(5))
      0: ;
      1: add_mixed("localhost", HOST_MAX);
      2: begin
        n = $urandom_range(1, 8);
        repeat (n) add_byte(host_char());
      end
      3: repeat (HOST_MAX) add_byte(host_char());
      4: begin
        n = $urandom_range(10, 14);
        repeat (n) add_byte(host_char());
      end
      default: begin
        add_mixed("localhost", HOST_MAX);
        add_byte(host_char());
      end
    endcase
  endtask

  // Mostly well-formed file URLs with random content; the rest is noise
  // and prefixes broken off part-way.
  task automatic build_url();
    int kind;
    int n;
    kind = $urandom_range(9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom_range(255)));
    end else if (kind == 1) begin
      add_mixed("file:/", $urandom_range(1, PREFIX_LEN - 1));
      if ($urandom_range(1) == 1) add_byte(8'($urandom_range(255)));
    end else if (kind <= 3) begin
      add_mixed("file:/", PREFIX_LEN);
      add_path($urandom_range(0, 10));
    end else begin
      add_mixed("file:/", PREFIX_LEN);
      add_byte(CH_SLASH);
      add_host();
      case ($urandom_range(9))
        0: ;
        1: begin
          add_byte(($urandom_range(1) == 1) ? CH_QUES : CH_HASH);
          add_path($urandom_range(0, 4));
        end
        default: begin
          add_byte(CH_SLASH);
          add_path($urandom_range(0, 10));
        end
      endcase
    end
  endtask

  // Offer one word from a falling edge and hold it until it is taken; on
  // return the word is still on the port, so the caller must either follow
  // with the next word or drop in_valid itself.
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_url();
    for (int i = 0; i < url_q.size(); i++) send_word(url_q[i], i == url_q.size() - 1);
    url_q.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_url();
  endtask

  // Hold the sender off until every predicted word has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
  endtask

  initial begin
    int phase_end;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    in_last  = 1'b0;
    rst_n    = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: mismatch on the first word, a short string that
    // stops inside the prefix, the bare prefix, escapes in both cases with
    // broken and trailing ones, localhost in mixed case, long hosts kept in
    // full, empty hosts that leave only an end marker, and raw echo of the
    // byte extremes.
    send_text("x");
    send_text("FiLe");
    send_text("FILE:/");
    send_text("file:/a%41%6a%zz%4g%");
    send_text("file://LocalHost/b%2");
    send_text("file://abcdefghijKL/p?q%41");
    send_text("file://srv?z");
    send_text("file://?");
    send_text("file:/x%4#tail");
    send_text("file://");
    send_text("file://localhostz/");
    send_text("file://ab");
    send_text("file:/?");
    url_q = '{8'h00, 8'hFF, 8'h66};
    send_url();
    drain_outputs();

    // Random strings under each idling pattern; drain between patterns
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 73;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 73;
        end
        default: begin
          idle_pct  = 6;
          stall_pct = 6;
        end
      endcase
      phase_end = words_sent + 20;
      while (words_sent < phase_end) begin
        build_url();
        send_url();
      end
      drain_outputs();
    end

    // Let any stray word out before the verdict
    stall_pct = 0;
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
src/fup_pkg.sv
src/fup_front.sv
src/fup_queue.sv
src/fup_back.sv
src/file_url_to_path_stream.sv
src/fup_checker.sv
verif/file_url_to_path_checker.sv
verif/file_url_to_path_stream_tb.sv
